// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sequence query engine.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/isrq_pkg.sv =====
// Package for the sequence query engine: sizes, opcodes, status codes.
// Depends on nothing.
`default_nettype none
package isrq_pkg;
   localparam int CAPACITY    = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam logic [3:0] OP_INSERT = 4'd0;
   localparam logic [3:0] OP_DELETE = 4'd1;
   localparam logic [3:0] OP_SET    = 4'd2;
   localparam logic [3:0] OP_GET    = 4'd3;
   localparam logic [3:0] OP_MIN    = 4'd4;
   localparam logic [3:0] OP_MAX    = 4'd5;
   localparam logic [3:0] OP_SUM    = 4'd6;
   localparam logic [3:0] OP_ROTR   = 4'd7;
   localparam logic [3:0] OP_ROTL   = 4'd8;
   localparam logic [3:0] OP_FIND   = 4'd9;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/isrq_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module isrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/indexed_sequence_range_query_engine.sv =====
// Top level of the indexed sequence range-query engine.
// Depends on isrq_pkg, isrq_ram and assert_macros.svh.
//
// One request at a time: a request is taken at a rising edge with start high
// and busy low. Responses are registered and appear for one cycle each with
// rsp_valid high. The receiver cannot stall them and must take every one.
// After the accepting edge busy covers S_DEC alone for every error, a set
// and a find on an empty sequence or with a zero limit; S_DEC and S_TAIL
// for an insert at the end or a delete of the last element; otherwise
// S_DEC, then S_RUN reading the elements (get one, min/max/sum/rotate r-l,
// insert n-pos, delete n-pos-1, find those scanned), then S_TAIL.
// The final response shows in the cycle after the last busy cycle, and the
// next request can be taken at the edge ending it. A find shows its
// matches one per cycle during the scan, each held back until the next
// match or S_TAIL, so that last can be set on the final match; the scan
// stops at the limit.
// Pipeline: read address issued, data back next cycle; a move writes each
// element one slot over while the next read runs two slots ahead of the
// write, so no entry is read after it has been overwritten within one pass.
`default_nettype none
`include "assert_macros.svh"
module indexed_sequence_range_query_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [5:0]  req_position,
   input  wire logic [5:0]  req_right_end,
   input  wire logic signed [31:0] req_value,
   input  wire logic [5:0]  req_match_limit,
   input  wire logic        req_find_request,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [4:0]       rsp_found_index,
   output logic             rsp_found,
   output logic             rsp_last,
   output logic [5:0]       rsp_length
);
   import isrq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEC  = 2'd1;  // decode, check, set up the reads
   localparam logic [1:0] S_RUN  = 2'd2;  // scan or move loop
   localparam logic [1:0] S_TAIL = 2'd3;  // final write / response

   logic [1:0]         state_ff, state_in;
   logic [3:0]         op_ff, op_in;
   logic [CNT_W-1:0]   pos_ff, pos_in, rend_ff, rend_in, lim_ff, lim_in;
   value_type          val_ff, val_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rd_ff, rd_in;      // next read index
   logic [CNT_W-1:0]   nrd_ff, nrd_in;    // reads still to issue
   logic               down_ff, down_in;  // walk toward index 0
   logic               rv_ff, rv_in;      // read data valid this cycle
   logic [IDX_W-1:0]   ri_ff, ri_in;      // index of data now arriving
   value_type          acc_ff, acc_in, hold_ff, hold_in;
   logic               first_ff, first_in;
   logic [CNT_W-1:0]   k_ff, k_in;        // matches taken
   logic               pend_ff, pend_in;  // a match waits to be shown
   logic [IDX_W-1:0]   pidx_ff, pidx_in;

   logic               we;
   logic [IDX_W-1:0]   wa;
   value_type          wd, rdat;

   logic               out_v;
   logic [1:0]         out_s;
   value_type          out_d;
   logic [IDX_W-1:0]   out_i;
   logic               out_f, out_l;

   isrq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_mem (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(rd_ff), .rd_data(rdat)
   );

   logic [CNT_W-1:0] rclamp;
   logic [CNT_W-1:0] span;
   always_comb begin
      rclamp = (rend_ff < cnt_ff) ? rend_ff : cnt_ff;
      span   = rclamp - pos_ff;  // only used when pos < rclamp
   end

   always_comb begin
      state_in = state_ff; op_in = op_ff; pos_in = pos_ff; rend_in = rend_ff;
      lim_in = lim_ff; val_in = val_ff; cnt_in = cnt_ff; rd_in = rd_ff;
      nrd_in = nrd_ff; down_in = down_ff; rv_in = 1'b0; ri_in = ri_ff;
      acc_in = acc_ff; hold_in = hold_ff; first_in = first_ff; k_in = k_ff;
      pend_in = pend_ff; pidx_in = pidx_ff;
      we = 1'b0; wa = ri_ff; wd = rdat;
      out_v = 1'b0; out_s = ST_OK; out_d = '0; out_i = '0; out_f = 1'b0;
      out_l = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_find_request ? OP_FIND : req_opcode;
               pos_in  = req_position[CNT_W-1:0];
               rend_in = req_right_end[CNT_W-1:0];
               lim_in  = (req_match_limit > 6'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                           : req_match_limit[CNT_W-1:0];
               val_in  = VALUE_WIDTH'(req_value);
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            first_in = 1'b1; k_in = '0; pend_in = 1'b0; down_in = 1'b0;
            state_in = S_RUN;
            case (op_ff)
               OP_INSERT: begin
                  if (pos_ff > cnt_ff) begin
                     out_v = 1'b1; out_s = ST_RANGE; state_in = S_IDLE;
                  end else if (cnt_ff >= CNT_W'(CAPACITY)) begin
                     out_v = 1'b1; out_s = ST_FULL; state_in = S_IDLE;
                  end else begin
                     // read cnt-1 downto pos, write each one up
                     rd_in = IDX_W'(cnt_ff - 1'b1); nrd_in = cnt_ff - pos_ff;
                     down_in = 1'b1;
                     if (cnt_ff == pos_ff) state_in = S_TAIL;
                  end
               end
               OP_DELETE: begin
                  if (pos_ff >= cnt_ff) begin
                     out_v = 1'b1; out_s = ST_RANGE; state_in = S_IDLE;
                  end else begin
                     // read pos+1 up to cnt-1, write each one down
                     rd_in = IDX_W'(pos_ff + 1'b1);
                     nrd_in = cnt_ff - pos_ff - 1'b1;
                     if (pos_ff + 1'b1 == cnt_ff) state_in = S_TAIL;
                  end
               end
               OP_SET: begin
                  if (pos_ff >= cnt_ff) out_s = ST_RANGE;
                  else begin
                     we = 1'b1; wa = IDX_W'(pos_ff); wd = val_ff;
                  end
                  out_v = 1'b1; state_in = S_IDLE;
               end
               OP_GET: begin
                  if (pos_ff >= cnt_ff) begin
                     out_v = 1'b1; out_s = ST_RANGE; state_in = S_IDLE;
                  end else begin
                     rd_in = IDX_W'(pos_ff); nrd_in = CNT_W'(1);
                  end
               end
               OP_MIN, OP_MAX, OP_SUM, OP_ROTR, OP_ROTL: begin
                  if (pos_ff >= rclamp) begin
                     out_v = 1'b1; out_s = ST_RANGE; state_in = S_IDLE;
                  end else begin
                     nrd_in = span;
                     if (op_ff == OP_ROTR) begin
                        // r-1 first into hold, then shift down to pos
                        rd_in = IDX_W'(rclamp - 1'b1); down_in = 1'b1;
                     end else rd_in = IDX_W'(pos_ff);
                  end
               end
               OP_FIND: begin
                  if (cnt_ff == '0 || lim_ff == '0) begin
                     out_v = 1'b1; state_in = S_IDLE;
                  end else begin
                     rd_in = '0; nrd_in = cnt_ff;
                  end
               end
               default: begin
                  out_v = 1'b1; out_s = ST_RANGE; state_in = S_IDLE;
               end
            endcase
         end
         S_RUN: begin
            if (nrd_ff != '0) begin
               rv_in = 1'b1; ri_in = rd_ff; nrd_in = nrd_ff - 1'b1;
               rd_in = down_ff ? rd_ff - 1'b1 : rd_ff + 1'b1;
            end
            if (rv_ff) begin
               // no read issued this cycle: this is the last data
               if (nrd_ff == '0) state_in = S_TAIL;
               case (op_ff)
                  OP_INSERT: begin
                     we = 1'b1; wa = ri_ff + 1'b1;
                  end
                  OP_DELETE: begin
                     we = 1'b1; wa = ri_ff - 1'b1;
                  end
                  OP_ROTR, OP_ROTL: begin
                     if (first_ff) hold_in = rdat;
                     else begin
                        we = 1'b1;
                        wa = (op_ff == OP_ROTR) ? ri_ff + 1'b1 : ri_ff - 1'b1;
                     end
                     first_in = 1'b0;
                  end
                  OP_FIND: begin
                     if (rdat == val_ff) begin
                        // show the previous match, keep this one back
                        if (pend_ff) begin
                           out_v = 1'b1; out_f = 1'b1; out_i = pidx_ff;
                           out_l = 1'b0;
                        end
                        pend_in = 1'b1; pidx_in = ri_ff; k_in = k_ff + 1'b1;
                        if (k_ff + 1'b1 == lim_ff) state_in = S_TAIL;
                     end
                  end
                  default: begin  // get, min, max, sum
                     if (first_ff) acc_in = rdat;
                     else if (op_ff == OP_MIN)
                        acc_in = ($signed(rdat) < $signed(acc_ff)) ? rdat : acc_ff;
                     else if (op_ff == OP_MAX)
                        acc_in = ($signed(rdat) > $signed(acc_ff)) ? rdat : acc_ff;
                     else acc_in = acc_ff + rdat;
                     first_in = 1'b0;
                  end
               endcase
            end
         end
         S_TAIL: begin
            state_in = S_IDLE; out_v = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  we = 1'b1; wa = IDX_W'(pos_ff); wd = val_ff;
                  cnt_in = cnt_ff + 1'b1;
               end
               OP_DELETE: cnt_in = cnt_ff - 1'b1;
               OP_ROTR: begin
                  we = 1'b1; wa = IDX_W'(pos_ff); wd = hold_ff;
               end
               OP_ROTL: begin
                  we = 1'b1; wa = IDX_W'(rclamp - 1'b1); wd = hold_ff;
               end
               OP_FIND: begin
                  // final match with last, or the single miss response
                  if (pend_ff) begin
                     out_f = 1'b1; out_i = pidx_ff;
                  end
               end
               OP_GET, OP_MIN, OP_MAX, OP_SUM: out_d = acc_ff;
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
      // a find stopped at its limit drops the read still in flight
      if (state_in != S_RUN) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; rv_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
         rsp_valid <= out_v;
      end
      op_ff <= op_in; pos_ff <= pos_in; rend_ff <= rend_in; lim_ff <= lim_in;
      val_ff <= val_in; rd_ff <= rd_in; nrd_ff <= nrd_in; down_ff <= down_in;
      ri_ff <= ri_in; acc_ff <= acc_in; hold_ff <= hold_in;
      first_ff <= first_in; k_ff <= k_in; pend_ff <= pend_in; pidx_ff <= pidx_in;
      rsp_status <= out_s; rsp_data <= 32'(out_d);
      rsp_found_index <= 5'(out_i); rsp_found <= out_f; rsp_last <= out_l;
      rsp_length <= 6'(cnt_in);
   end

   assign busy = (state_ff != S_IDLE);

   `ASSERT_IMPLY(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_start_dec, clock, reset, start && !busy, state_ff == S_DEC)
   `ASSERT_IMPLY(a_wr_busy, clock, reset, we, state_ff != S_IDLE)
endmodule
`default_nettype wire

// ===== verif/tb_indexed_sequence_range_query_engine.sv =====
// Self-checking testbench for the indexed sequence range-query engine.
// Depends on isrq_pkg and the RTL top level; carries its own sequence predictor.
module tb_indexed_sequence_range_query_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import isrq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   // Expected response as it should appear on the rsp_ ports.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data;
      logic [4:0]  found_index;
      logic        found;
      logic        last;
      logic [5:0]  length;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0]  req_opcode = '0;
   logic [5:0]  req_position = '0;
   logic [5:0]  req_right_end = '0;
   logic signed [31:0] req_value = '0;
   logic [5:0]  req_match_limit = '0;
   logic        req_find_request = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic signed [31:0] rsp_data;
   logic [4:0]  rsp_found_index;
   logic        rsp_found;
   logic        rsp_last;
   logic [5:0]  rsp_length;

   // Mirror of the sequence contents, kept by the predictor.
   value_type  seq_model [CAPACITY];
   int unsigned seq_len;

   response_type pending_rsp[$];
   int unsigned mismatches;
   int unsigned requests_sent;
   int unsigned responses_seen;
   int unsigned idle_cycles = 0;
   int unsigned sender_idle_pct;
   bit          timed_out = 1'b0;

   indexed_sequence_range_query_engine u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_position(req_position),
      .req_right_end(req_right_end), .req_value(req_value),
      .req_match_limit(req_match_limit), .req_find_request(req_find_request),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_found_index(rsp_found_index), .rsp_found(rsp_found),
      .rsp_last(rsp_last), .rsp_length(rsp_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic response_type plain_rsp(logic [1:0] st, logic [31:0] d);
      response_type r;
      r = '0;
      r.status = st;
      r.data   = d;
      r.last   = 1'b1;
      r.length = seq_len[5:0];
      return r;
   endfunction

   // Appends one expectation at the tail of the queue.
   function automatic void expect_rsp(response_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // Applies one request to the mirror and queues every response it causes.
   task automatic predict_request(logic [3:0] op, logic [5:0] pos, logic [5:0] rend,
                                  logic [31:0] val, logic [5:0] lim, logic fnd);
      int unsigned r, i, hits, cap;
      value_type acc, t;
      response_type rr;
      if (fnd) op = OP_FIND;
      if (op == OP_FIND) begin
         cap = (lim > CAPACITY) ? CAPACITY : lim;
         hits = 0;
         for (i = 0; i < seq_len && hits < cap; i++) begin
            if (seq_model[i] == val) begin
               rr = plain_rsp(ST_OK, '0);
               rr.found_index = i[4:0];
               rr.found = 1'b1;
               rr.last = 1'b0;
               expect_rsp(rr);
               hits++;
            end
         end
         if (hits == 0) expect_rsp(plain_rsp(ST_OK, '0));
         else pending_rsp[$].last = 1'b1;
         return;
      end
      case (op)
         OP_INSERT: begin
            if (pos > seq_len) expect_rsp(plain_rsp(ST_RANGE, '0));
            else if (seq_len >= CAPACITY) expect_rsp(plain_rsp(ST_FULL, '0));
            else begin
               for (i = seq_len; i > pos; i--) seq_model[i] = seq_model[i-1];
               seq_model[pos] = val;
               seq_len++;
               expect_rsp(plain_rsp(ST_OK, '0));
            end
         end
         OP_DELETE: begin
            if (pos >= seq_len) expect_rsp(plain_rsp(ST_RANGE, '0));
            else begin
               for (i = pos; i + 1 < seq_len; i++) seq_model[i] = seq_model[i+1];
               seq_len--;
               expect_rsp(plain_rsp(ST_OK, '0));
            end
         end
         OP_SET: begin
            if (pos >= seq_len) expect_rsp(plain_rsp(ST_RANGE, '0));
            else begin
               seq_model[pos] = val;
               expect_rsp(plain_rsp(ST_OK, '0));
            end
         end
         OP_GET: begin
            if (pos >= seq_len) expect_rsp(plain_rsp(ST_RANGE, '0));
            else expect_rsp(plain_rsp(ST_OK, seq_model[pos]));
         end
         OP_MIN, OP_MAX, OP_SUM, OP_ROTR, OP_ROTL: begin
            r = (rend < seq_len) ? rend : seq_len;
            if (pos >= r) expect_rsp(plain_rsp(ST_RANGE, '0));
            else if (op == OP_ROTR) begin
               t = seq_model[r-1];
               for (i = r - 1; i > pos; i--) seq_model[i] = seq_model[i-1];
               seq_model[pos] = t;
               expect_rsp(plain_rsp(ST_OK, '0));
            end else if (op == OP_ROTL) begin
               t = seq_model[pos];
               for (i = pos; i + 1 < r; i++) seq_model[i] = seq_model[i+1];
               seq_model[r-1] = t;
               expect_rsp(plain_rsp(ST_OK, '0));
            end else begin
               acc = seq_model[pos];
               for (i = pos + 1; i < r; i++) begin
                  t = seq_model[i];
                  if (op == OP_MIN) begin
                     if ($signed(t) < $signed(acc)) acc = t;
                  end else if (op == OP_MAX) begin
                     if ($signed(t) > $signed(acc)) acc = t;
                  end else acc = acc + t;
               end
               expect_rsp(plain_rsp(ST_OK, acc));
            end
         end
         default: expect_rsp(plain_rsp(ST_RANGE, '0));
      endcase
   endtask

   // Drives one request, holds start until the block takes it, then predicts.
   // start stays high after the accepting edge; the next call or the drain
   // decides what it does next, so it is driven once per edge at most.
   task automatic send_request(logic [3:0] op, logic [5:0] pos, logic [5:0] rend,
                               logic [31:0] val, logic [5:0] lim, logic fnd);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_opcode       <= op;
      req_position     <= pos;
      req_right_end    <= rend;
      req_value        <= val;
      req_match_limit  <= lim;
      req_find_request <= fnd;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      predict_request(op, pos, rend, val, lim, fnd);
      requests_sent++;
   endtask

   // Response checker: each strobe is compared with the oldest expectation.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_data !== want.data ||
                rsp_found_index !== want.found_index || rsp_found !== want.found ||
                rsp_last !== want.last || rsp_length !== want.length) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st=%0d d=%h ix=%0d f=%b l=%b n=%0d",
                           want.status, want.data, want.found_index, want.found,
                           want.last, want.length);
                  $display("          got st=%0d d=%h ix=%0d f=%b l=%b n=%0d",
                           rsp_status, rsp_data, rsp_found_index, rsp_found,
                           rsp_last, rsp_length);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out <= 1'b1;
         $display("watchdog expired");
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic drain_responses();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Random 32-bit values, sometimes from a small pool so finds hit.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return 32'($urandom_range(3));
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      // extremes at the empty sequence: every op must report an error or miss
      send_request(OP_GET, 0, 0, 0, 0, 0);
      send_request(OP_DELETE, 0, 0, 0, 0, 0);
      send_request(OP_SUM, 0, 32, 0, 0, 0);
      send_request(OP_FIND, 0, 0, 0, 32, 0);
      send_request(OP_INSERT, 1, 0, 0, 0, 0);           // past the end
      send_request(OP_INSERT, 0, 0, 32'h7fff_ffff, 0, 0);
      send_request(OP_INSERT, 1, 0, 32'h8000_0000, 0, 0);
      send_request(OP_INSERT, 1, 0, 32'h7fff_ffff, 0, 0);
      send_request(OP_MIN, 0, 63, 0, 0, 0);             // right end clamped
      send_request(OP_MAX, 0, 3, 0, 0, 0);
      send_request(OP_SUM, 0, 3, 0, 0, 0);              // wrapping sum
      send_request(OP_ROTR, 0, 3, 0, 0, 0);
      send_request(OP_ROTL, 0, 3, 0, 0, 0);
      send_request(OP_ROTR, 1, 2, 0, 0, 0);             // single element
      send_request(OP_MIN, 2, 2, 0, 0, 0);              // empty range
      send_request(OP_SET, 2, 0, 32'hffff_ffff, 0, 0);
      send_request(OP_SET, 63, 0, 0, 0, 0);
      send_request(4'd15, 63, 63, 32'hffff_ffff, 63, 0); // unused opcode
      send_request(4'd12, 0, 0, 32'h7fff_ffff, 0, 1);   // find overrides opcode
      send_request(OP_FIND, 0, 0, 32'h7fff_ffff, 0, 0); // zero limit
      send_request(OP_FIND, 0, 0, 32'h7fff_ffff, 1, 0);
      send_request(OP_GET, 2, 0, 0, 0, 0);
      send_request(OP_DELETE, 1, 0, 0, 0, 0);
      drain_responses();
   endtask

   task automatic test_fill_and_find();
      int k;
      // fill to capacity, then hit the full error and a full-length find
      while (seq_len < CAPACITY) send_request(OP_INSERT, 0, 0, 32'h5, 0, 0);
      send_request(OP_INSERT, 0, 0, 0, 0, 0);
      send_request(OP_INSERT, 33, 0, 0, 0, 0);
      send_request(OP_FIND, 0, 0, 32'h5, 63, 0);
      send_request(OP_SUM, 0, 32, 0, 0, 0);
      send_request(OP_ROTL, 0, 32, 0, 0, 0);
      send_request(OP_DELETE, 31, 0, 0, 0, 0);
      for (k = 0; k < 20; k++) send_request(OP_DELETE, 0, 0, 0, 0, 0);
      drain_responses();
   endtask

   task automatic test_random(int unsigned count, int unsigned idle_pct);
      int unsigned k;
      logic [3:0] op;
      logic [5:0] pos, rend;
      sender_idle_pct = idle_pct;
      for (k = 0; k < count; k++) begin
         // bias toward inserts when short, deletes when long
         op = 4'($urandom_range(9));
         if (seq_len < 6 && $urandom_range(2) == 0) op = OP_INSERT;
         if (seq_len > 28 && $urandom_range(2) == 0) op = OP_DELETE;
         if ($urandom_range(19) == 0) op = 4'($urandom_range(15));
         pos  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(seq_len));
         rend = ($urandom_range(9) == 0) ? 6'($urandom)
                                         : 6'($urandom_range(seq_len + 1));
         send_request(op, pos, rend, pick_value(), 6'($urandom),
                      $urandom_range(15) == 0);
      end
      drain_responses();
      sender_idle_pct = 0;
   endtask

   initial begin
      mismatches = 0; requests_sent = 0; responses_seen = 0;
      sender_idle_pct = 0; seq_len = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_find();
      test_random(8, 0);
      test_random(8, 50);
      test_random(7, 9);
      test_random(7, 0);
      $display("covered %0d requests and %0d responses over empty, full and partial",
               requests_sent, responses_seen);
      $display("sequences, with and without sender gaps");
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
